// ===== hdl/ectr_pkg.sv =====
// Package for the event-cartridge timer and ROM banking core.
// Holds widths, codes, the FSM type, inter-module structs and the address map.
// No dependencies.
package ectr_pkg;

  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned OFF_W    = 22;
  localparam int unsigned SIZE_W   = 23;
  localparam int unsigned TSEC_W   = 16;
  localparam int unsigned SCORE_W  = 3;
  localparam int unsigned ID_W     = 2;
  localparam int unsigned NUM_ROMS = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned STEP_W   = 5;

  localparam logic [SIZE_W-1:0] ROM_SIZE_RESET = 23'h100000;
  localparam logic [SCORE_W-1:0] SCORE_SECONDS = 3'd5;
  localparam logic [DATA_W-1:0] STATUS_TIME_OVER = 8'h02;

  // select byte codes
  localparam logic [DATA_W-1:0] SEL_START    = 8'h09;
  localparam logic [DATA_W-1:0] SEL_A_ROM2   = 8'h05;
  localparam logic [DATA_W-1:0] SEL_A_ROM3   = 8'h03;
  localparam logic [DATA_W-1:0] SEL_B_ROM2   = 8'h0c;
  localparam logic [DATA_W-1:0] SEL_B_ROM3   = 8'h0a;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_STATUS = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_ROM    = 2'd3
  } mode_t;

  typedef enum logic [ID_W-1:0] {
    ROM0 = 2'd0,
    ROM1 = 2'd1,
    ROM2 = 2'd2,
    ROM3 = 2'd3
  } rom_id_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_TYPE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_SEC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE_2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE_3 = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_FOLD = 2'd1,
    ST_DONE = 2'd2
  } ectr_state_t;

  typedef struct packed {
    logic              tick;
    logic              write;
    logic [DATA_W-1:0] data;
  } tmr_cmd_t;

  typedef struct packed {
    logic              start;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
  } fold_req_t;

  typedef struct packed {
    logic             done;
    logic [OFF_W-1:0] offset;
  } fold_rsp_t;

  typedef struct packed {
    logic             hit;
    rom_id_t          id;
    logic [OFF_W-1:0] offset;
  } map_t;

  // Pick a ROM and build the unmirrored offset for one bus address.
  function automatic map_t map_read(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] sel,
                                    logic board);
    map_t m;
    m.hit    = 1'b0;
    m.id     = ROM0;
    m.offset = '0;
    if (!board) begin
      if (sel == SEL_START)  m.id = ROM1;
      if (sel == SEL_A_ROM2) m.id = ROM2;
      if (sel == SEL_A_ROM3) m.id = ROM3;
      if (addr[23] && addr[15]) m.id = ROM0;
      if (addr[15]) begin
        m.offset = {addr[22:16], addr[14:0]};
        m.hit    = 1'b1;
      end
    end else begin
      if (sel == SEL_START)  m.id = ROM1;
      if (sel == SEL_B_ROM2) m.id = ROM2;
      if (sel == SEL_B_ROM3) m.id = ROM3;
      if (addr[21] && addr[15]) m.id = ROM0;
      if (addr[22]) begin
        m.offset = addr[21:0];
        m.hit    = 1'b1;
      end else if (addr[15]) begin
        if (m.id == ROM2) m.offset = {1'b0, addr[20:0]};
        else              m.offset = {2'b00, addr[20:16], addr[14:0]};
        m.hit = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

// ===== hdl/ectr_if.sv =====
// Valid/ready channels for the bus event word and the result word.
// Depends on ectr_pkg.
interface ectr_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic [ectr_pkg::ADDR_W-1:0]  bus_address;
  logic [ectr_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, mode, bus_address, write_data, input ready);
  modport sink   (input valid, mode, bus_address, write_data, output ready);
endinterface

interface ectr_out_if;
  logic                        valid;
  logic                        ready;
  logic [ectr_pkg::DATA_W-1:0] status_byte;
  logic                        rom_hit;
  logic [ectr_pkg::ID_W-1:0]   rom_id;
  logic [ectr_pkg::OFF_W-1:0]  rom_offset;

  modport source (output valid, status_byte, rom_hit, rom_id, rom_offset, input ready);
  modport sink   (input valid, status_byte, rom_hit, rom_id, rom_offset, output ready);
endinterface

// ===== hdl/ectr_timer.sv =====
// Countdown timer, score phase, status and select registers.
// Depends on ectr_pkg.
module ectr_timer (
  input  logic                         clk,
  input  logic                         rst,
  input  ectr_pkg::tmr_cmd_t           cmd,
  input  logic [ectr_pkg::TSEC_W-1:0]  timer_seconds,
  output logic [ectr_pkg::DATA_W-1:0]  status,
  output logic [ectr_pkg::DATA_W-1:0]  select
);
  import ectr_pkg::*;

  logic                status_reg, status_reg_next;
  logic [DATA_W-1:0]   select_reg, select_reg_next;
  logic                timer_running, timer_running_next;
  logic [TSEC_W-1:0]   timer_left, timer_left_next;
  logic                score_running, score_running_next;
  logic [SCORE_W-1:0]  score_left, score_left_next;

  always_comb begin
    status_reg_next    = status_reg;
    select_reg_next    = select_reg;
    timer_running_next = timer_running;
    timer_left_next    = timer_left;
    score_running_next = score_running;
    score_left_next    = score_left;
    if (cmd.tick) begin
      if (score_running && score_left != '0) begin
        score_left_next = score_left - 1'b1;
        if (score_left == SCORE_W'(1)) score_running_next = 1'b0;
      end
      if (timer_running && timer_left != '0) begin
        timer_left_next = timer_left - 1'b1;
        // expiry: flag time over and open the score phase
        if (timer_left == TSEC_W'(1)) begin
          timer_running_next = 1'b0;
          status_reg_next    = 1'b1;
          score_running_next = 1'b1;
          score_left_next    = SCORE_SECONDS;
        end
      end
    end else if (cmd.write) begin
      select_reg_next = cmd.data;
      if (timer_seconds != '0 && cmd.data == SEL_START) begin
        timer_running_next = 1'b1;
        timer_left_next    = timer_seconds;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_reg    <= 1'b0;
      select_reg    <= '0;
      timer_running <= 1'b0;
      timer_left    <= '0;
      score_running <= 1'b0;
      score_left    <= '0;
    end else begin
      status_reg    <= status_reg_next;
      select_reg    <= select_reg_next;
      timer_running <= timer_running_next;
      timer_left    <= timer_left_next;
      score_running <= score_running_next;
      score_left    <= score_left_next;
    end
  end

  assign status = status_reg ? STATUS_TIME_OVER : '0;
  assign select = select_reg;

endmodule

// ===== hdl/ectr_fold.sv =====
// Bit-serial mirror unit: folds an offset into a ROM size, one address bit per cycle,
// highest bit first. Depends on ectr_pkg.
module ectr_fold (
  input  logic                clk,
  input  logic                rst,
  input  ectr_pkg::fold_req_t req,
  output ectr_pkg::fold_rsp_t rsp
);
  import ectr_pkg::*;

  logic [OFF_W-1:0]  a;
  logic [SIZE_W-1:0] sz;
  logic [OFF_W-1:0]  base;
  logic [STEP_W-1:0] k;
  logic              busy;
  logic              done;
  logic              above;
  logic              size_wider;
  logic [SIZE_W-1:0] low_mask;

  assign above      = {1'b0, a} >= sz;
  assign low_mask   = (SIZE_W'(1) << k) - SIZE_W'(1);
  // size is below twice this bit here, so size > bit means bit k set plus lower bits
  assign size_wider = sz[k] && ((sz & low_mask) != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= busy && (k == '0);
      if (req.start) begin
        busy <= 1'b1;
        k    <= STEP_W'(OFF_W - 1);
      end else if (busy) begin
        if (k == '0) busy <= 1'b0;
        else         k    <= k - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a    <= req.offset;
      sz   <= req.size;
      base <= '0;
    end else if (busy && above && a[k]) begin
      // drop the bit; move it to the base when the size still covers it
      a[k] <= 1'b0;
      if (size_wider) begin
        sz[k]   <= 1'b0;
        base[k] <= 1'b1;
      end
    end
  end

  // base and remaining offset never share a bit
  assign rsp.done   = done;
  assign rsp.offset = base | a;

endmodule

// ===== hdl/event_cart_timer_and_rom_banking_core.sv =====
// Event-cartridge timer and ROM banking core.
// One word in flight at a time. Tick, status, data-write and missed ROM-read words pass from
// ST_IDLE through ST_DONE to the output register; the next word is taken back in ST_IDLE.
// ROM reads that hit go through ST_FOLD, where the bit-serial mirror unit folds the offset
// one bit per cycle, highest bit first, then through ST_DONE to the output register.
// Reset (synchronous) clears all timer state and restores register defaults.
module event_cart_timer_and_rom_banking_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ectr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ectr_pkg::SIZE_W-1:0]      cfg_data,
  ectr_in_if.sink                          item,
  ectr_out_if.source                       result
);
  import ectr_pkg::*;

  ectr_state_t       state, state_next;
  logic              board_type;
  logic [TSEC_W-1:0] timer_seconds;
  logic [SIZE_W-1:0] rom_size [NUM_ROMS];

  tmr_cmd_t          tcmd;
  fold_req_t         freq;
  fold_rsp_t         frsp;
  logic [DATA_W-1:0] status;
  logic [DATA_W-1:0] select;

  map_t              m;
  logic [SIZE_W-1:0] sel_size;
  logic              accept;
  logic              read_hit;
  logic              out_free;

  logic              res_hit;
  rom_id_t           res_id;
  logic [OFF_W-1:0]  res_off;
  logic              load_out;

  logic              out_valid;
  logic [DATA_W-1:0] out_status;
  logic              out_hit;
  logic [ID_W-1:0]   out_id;
  logic [OFF_W-1:0]  out_off;

  ectr_timer u_timer (
    .clk           (clk),
    .rst           (rst),
    .cmd           (tcmd),
    .timer_seconds (timer_seconds),
    .status        (status),
    .select        (select)
  );

  ectr_fold u_fold (
    .clk (clk),
    .rst (rst),
    .req (freq),
    .rsp (frsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      board_type    <= 1'b0;
      timer_seconds <= '0;
      for (int i = 0; i < NUM_ROMS; i++) rom_size[i] <= ROM_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOARD_TYPE: board_type    <= cfg_data[0];
        CFG_TIMER_SEC:  timer_seconds <= cfg_data[TSEC_W-1:0];
        CFG_ROM_SIZE_0: rom_size[0]   <= cfg_data;
        CFG_ROM_SIZE_1: rom_size[1]   <= cfg_data;
        CFG_ROM_SIZE_2: rom_size[2]   <= cfg_data;
        CFG_ROM_SIZE_3: rom_size[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept   = item.valid && item.ready;
  assign m        = map_read(item.bus_address, select, board_type);
  assign sel_size = rom_size[m.id];
  assign read_hit = (mode_t'(item.mode) == MODE_ROM) && m.hit && (sel_size != '0);
  assign out_free = !out_valid || result.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = read_hit ? ST_FOLD : ST_DONE;
      ST_FOLD: if (frsp.done) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item.ready  = 1'b0;
    tcmd        = '0;
    freq.start  = 1'b0;
    freq.offset = m.offset;
    freq.size   = sel_size;
    load_out    = 1'b0;
    tcmd.data   = item.write_data;
    case (state)
      ST_IDLE: begin
        item.ready = 1'b1;
        if (accept) begin
          tcmd.tick  = mode_t'(item.mode) == MODE_TICK;
          tcmd.write = mode_t'(item.mode) == MODE_WRITE;
          freq.start = read_hit;
        end
      end
      ST_FOLD: ;
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // pending result of the word in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      res_hit <= read_hit;
      res_id  <= read_hit ? m.id : ROM0;
      res_off <= '0;
    end else if (state == ST_FOLD && frsp.done) begin
      res_off <= frsp.offset;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= status;
      out_hit    <= res_hit;
      out_id     <= res_id;
      out_off    <= res_off;
    end
  end

  assign result.valid       = out_valid;
  assign result.status_byte = out_status;
  assign result.rom_hit     = out_hit;
  assign result.rom_id      = out_id;
  assign result.rom_offset  = out_off;

endmodule

// ===== hdl/ectr_chk.sv =====
// Port-level checker for the event-cartridge core, bound to the top level.
// Depends on ectr_pkg.
module ectr_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [ectr_pkg::DATA_W-1:0] status_byte,
  input logic                        rom_hit,
  input logic [ectr_pkg::ID_W-1:0]   rom_id,
  input logic [ectr_pkg::OFF_W-1:0]  rom_offset
);
  import ectr_pkg::*;

  // a miss carries no ROM number and no offset
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && !rom_hit |-> rom_id == '0 && rom_offset == '0)
    else $error("miss word carries a ROM number or offset");

  // only the time-over flag lives in the status byte
  a_status_bits: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (status_byte & ~STATUS_TIME_OVER) == '0)
    else $error("status byte has bits other than time over");

  // one word at a time: no second word straight after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("word accepted while another is in flight");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status_byte) && $stable(rom_hit)
      && $stable(rom_id) && $stable(rom_offset))
    else $error("stalled result changed");

endmodule

bind event_cart_timer_and_rom_banking_core ectr_chk u_ectr_chk (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .item_ready  (item.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .status_byte (result.status_byte),
  .rom_hit     (result.rom_hit),
  .rom_id      (result.rom_id),
  .rom_offset  (result.rom_offset)
);
